/* rtl/sli_pkg.sv */
package sli_pkg;

   // Store geometry
   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 5;

   // Operation codes carried on the request tuser
   typedef enum logic [0:0] {
      ACT_INSERT = 1'b0,
      ACT_DELETE = 1'b1
   } action_type;

   // Result status carried on the response tuser
   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_DELETED   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Flags from the shared compare unit
   typedef struct packed {
      logic lt;   // a < b, signed
      logic eq;   // a == b
   } cmp_flags_type;

endpackage

/* rtl/sli_cmp.sv */
module sli_cmp
   import sli_pkg::*;
(
   input  logic signed [DATA_W-1:0] a,
   input  logic signed [DATA_W-1:0] b,
   output cmp_flags_type            flags
);

   // One signed compare, shared by insert and delete walks
   always_comb begin
      flags.lt = (a < b);
      flags.eq = (a == b);
   end

endmodule

/* rtl/sorted_list_insert_delete.sv */
// Sorted store of up to DEPTH signed 32-bit values in ascending order, duplicates
// allowed. A request word (tuser = action, tdata = value) inserts the value before
// any equal entries, or deletes the first equal entry; each request returns one
// response word with status, entry count and the smallest stored value. The
// entries sit in one memory walked by one comparator, with a read state and a
// compare state per entry touched: an insert walks back from the tail, moving
// every entry not smaller than the value up one place, and writes the value in
// the gap it leaves, at the head if it gets there; a delete scans the whole list
// from the head, closing the gap behind the match. A refused insert or a delete
// on an empty store goes straight to the response without reading the memory.
// The block takes no new request until the current one has been placed in the
// response register; a finished response may wait there while the next request
// is accepted.
module sorted_list_insert_delete
   import sli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] value
   input  logic [0:0]  req_tuser,    // [0] action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [4:0] entry_count, [5] head_valid,
                                     // [37:6] head_value, [39:38] zero
   output logic [1:0]  rsp_tuser     // [1:0] status
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_CMP  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         k_ff, k_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   action_type               act_ff, act_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic                     found_ff, found_in;
   status_type               status_ff, status_in;
   logic signed [DATA_W-1:0] head_ff, head_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]         rsp_cnt_ff, rsp_cnt_in;
   logic signed [DATA_W-1:0] rsp_head_ff, rsp_head_in;

   // entry memory
   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]         rd_addr;
   logic                     rd_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic                     wr_en;

   logic [CNT_W-1:0]         k_dec;
   logic [CNT_W-1:0]         k_inc;
   cmp_flags_type            flags;
   logic                     out_free;

   assign k_dec    = k_ff - CNT_W'(1);
   assign k_inc    = k_ff + CNT_W'(1);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // shared comparator: stored entry against the request value
   sli_cmp u_cmp (
      .a     (rd_data_ff),
      .b     (val_ff),
      .flags (flags)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      cnt_in        = cnt_ff;
      act_in        = act_ff;
      val_in        = val_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      head_in       = head_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_head_in   = rsp_head_ff;
      rd_en         = 1'b0;
      rd_addr       = k_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = k_ff[IDX_W-1:0];
      wr_data       = val_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in   = action_type'(req_tuser[0]);
               val_in   = req_tdata;
               found_in = 1'b0;
               if (action_type'(req_tuser[0]) == ACT_INSERT) begin
                  k_in = cnt_ff;
                  if (cnt_ff == CNT_W'(DEPTH)) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  k_in = '0;
                  if (cnt_ff == '0) begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end

         S_READ: begin
            if (act_ff == ACT_INSERT) begin
               if (k_ff == '0) begin
                  // reached the head: the value lands at position 0
                  wr_en     = 1'b1;
                  wr_addr   = '0;
                  wr_data   = val_ff;
                  status_in = ST_INSERTED;
                  state_in  = S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = k_dec[IDX_W-1:0];
                  state_in = S_CMP;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = k_ff[IDX_W-1:0];
               state_in = S_CMP;
            end
         end

         S_CMP: begin
            if (act_ff == ACT_INSERT) begin
               wr_en   = 1'b1;
               wr_addr = k_ff[IDX_W-1:0];
               if (!flags.lt) begin
                  // entry not smaller: move it up one place
                  wr_data  = rd_data_ff;
                  k_in     = k_dec;
                  state_in = S_READ;
               end else begin
                  wr_data   = val_ff;
                  status_in = ST_INSERTED;
                  state_in  = S_DONE;
               end
            end else begin
               // behind the match every entry moves down one place
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = k_dec[IDX_W-1:0];
                  wr_data = rd_data_ff;
               end else if (flags.eq) begin
                  found_in = 1'b1;
               end
               if (k_inc == cnt_ff) begin
                  status_in = (found_ff || flags.eq) ? ST_DELETED : ST_NOT_FOUND;
                  state_in  = S_DONE;
               end else begin
                  k_in     = k_inc;
                  state_in = S_READ;
               end
            end
         end

         S_DONE: begin
            if (out_free) begin
               priority case (status_ff)
                  ST_INSERTED: cnt_in = cnt_ff + CNT_W'(1);
                  ST_DELETED:  cnt_in = cnt_ff - CNT_W'(1);
                  default:     cnt_in = cnt_ff;
               endcase
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_cnt_in    = cnt_in;
               rsp_head_in   = head_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // head copy follows every write to position 0
      if (wr_en && (wr_addr == '0)) begin
         head_in = wr_data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      act_ff        <= act_in;
      val_ff        <= val_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      head_ff       <= head_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_head_ff   <= rsp_head_in;
   end

   // entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00,
                        (rsp_cnt_ff != '0) ? rsp_head_ff : {DATA_W{1'b0}},
                        (rsp_cnt_ff != '0),
                        COUNT_W'(rsp_cnt_ff)};

   // checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> (rsp_cnt_ff == CNT_W'(DEPTH)))
      else $error("full status with room left");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_cnt_ff)))
      else $error("pending response overwritten");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free && status_ff == ST_INSERTED)
         |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("insert did not grow the count");

endmodule
